/* rtl/nafe_pkg.sv */
// Shared types, character codes and constants of the nested array field extractor.
`timescale 1ns / 1ps

package nafe_pkg;

   localparam int FRAC_DIGITS  = 8;
   localparam int VALUE_W      = 52;
   localparam int ACC_EXT_W    = VALUE_W + 5;
   localparam int POW_W        = 40;
   localparam int ADD_W        = POW_W + 4;

   localparam logic [6:0] COUNT_LIMIT  = 7'd64;
   localparam logic [6:0] MAX_VALUES_RESET = 7'd48;
   localparam logic [7:0] TARGET_DEPTH = 8'd2;
   localparam logic [2:0] TARGET_FIELD = 3'd4;
   localparam logic [2:0] FIELD_MAX    = 3'd7;

   localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_POINT  = 8'h2E;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;

   typedef enum logic [2:0] {
      PH_AWAIT    = 3'd0,
      PH_POS_SIGN = 3'd1,
      PH_NEG_SIGN = 3'd2,
      PH_POS_INT  = 3'd3,
      PH_NEG_INT  = 3'd4,
      PH_POS_FRAC = 3'd5,
      PH_NEG_FRAC = 3'd6,
      PH_STOP     = 3'd7
   } phase_type;

   typedef struct packed {
      phase_type                  phase;
      logic [3:0]                 frac_cnt;
      logic signed [VALUE_W-1:0]  acc;
   } conv_state_type;

   typedef struct packed {
      logic                       has_value;
      logic signed [VALUE_W-1:0]  value;
      logic [5:0]                 value_index;
      logic                       text_done;
      logic [6:0]                 value_count;
   } result_type;

   function automatic logic [POW_W-1:0] pow10(input logic [3:0] n);
      logic [POW_W-1:0] p;
      case (n)
         4'd0:    p = 40'd1;
         4'd1:    p = 40'd10;
         4'd2:    p = 40'd100;
         4'd3:    p = 40'd1000;
         4'd4:    p = 40'd10000;
         4'd5:    p = 40'd100000;
         4'd6:    p = 40'd1000000;
         4'd7:    p = 40'd10000000;
         4'd8:    p = 40'd100000000;
         4'd9:    p = 40'd1000000000;
         4'd10:   p = 40'd10000000000;
         4'd11:   p = 40'd100000000000;
         4'd12:   p = 40'd1000000000000;
         default: p = '0;
      endcase
      return p;
   endfunction

endpackage

/* rtl/nested_array_field_extractor.sv */
// Top level of the nested array field extractor: input register, control register, ports.
`timescale 1ns / 1ps

// One text byte is taken per cycle while the input side is not stalled. A byte's result, if
// any, is presented on the rsp port from the result register. The accepting edge loads the
// input register; a later edge, once the result register is free, carries the byte through the
// parser into the result register. A waiting result holds the input register, and the input
// side stalls once both registers are full. A result is produced for every byte that closes a
// field-4 string of an inner array (while under the value limit) and for every byte marked last.
// The limit is min(max_values, 64). The user writes it on the csr port between texts; unenforced.
module nested_array_field_extractor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   input  logic        req_tuser,   // [0] first_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [51:0] value, [57:52] value_index,
                                    // [64:58] value_count, [71:65] zero
   output logic        rsp_tuser,   // [0] has_value
   output logic        rsp_tlast,   // text_done
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data  // max_values
);
   import nafe_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_first_ff;
   logic       in_last_ff;
   logic [6:0] max_values_ff;
   logic       item_take;
   logic       accept;
   result_type rsp;

   assign req_tready  = !in_valid_ff || item_take;
   assign accept      = req_tvalid && req_tready;
   assign in_valid_in = accept ? 1'b1 : (item_take ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         max_values_ff <= MAX_VALUES_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_wr_en) begin
            max_values_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff  <= req_tdata;
         in_first_ff <= req_tuser;
         in_last_ff  <= req_tlast;
      end
   end

   nafe_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .item_valid (in_valid_ff),
      .text_byte  (in_byte_ff),
      .first_byte (in_first_ff),
      .last_byte  (in_last_ff),
      .max_values (max_values_ff),
      .out_ready  (rsp_tready),
      .item_take  (item_take),
      .rsp_valid  (rsp_tvalid),
      .rsp        (rsp)
   );

   assign rsp_tdata = {7'd0, rsp.value_count, rsp.value_index, rsp.value};
   assign rsp_tuser = rsp.has_value;
   assign rsp_tlast = rsp.text_done;

endmodule

/* rtl/nafe_conv.sv */
// Next-state logic of the number converter for one character inside a string.
`timescale 1ns / 1ps

module nafe_conv (
   input  logic [7:0]              char_in,
   input  nafe_pkg::conv_state_type cur,
   output nafe_pkg::conv_state_type nxt
);
   import nafe_pkg::*;

   localparam logic signed [ACC_EXT_W-1:0] WIDE_MAX = ACC_EXT_W'(VALUE_MAX);
   localparam logic signed [ACC_EXT_W-1:0] WIDE_MIN = ACC_EXT_W'(VALUE_MIN);

   logic                        is_digit;
   logic                        is_space;
   logic [3:0]                  digit;
   logic                        skip;
   phase_type                   eff_ph;
   logic                        neg;
   logic                        int_mode;
   logic [3:0]                  frac_idx;
   logic [ADD_W-1:0]            add_amt;
   logic signed [ACC_EXT_W-1:0] acc_ext;
   logic signed [ACC_EXT_W-1:0] base;
   logic signed [ACC_EXT_W-1:0] add_ext;
   logic signed [ACC_EXT_W-1:0] sum;
   logic signed [VALUE_W-1:0]   clamped;

   assign is_digit = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
   assign is_space = (char_in == CH_SPACE) || ((char_in >= CH_TAB) && (char_in <= CH_CR));
   assign digit    = is_digit ? char_in[3:0] : 4'd0;

   always_comb begin
      skip   = 1'b0;
      eff_ph = cur.phase;
      if (cur.phase == PH_AWAIT) begin
         if (is_space || char_in == CH_PLUS || char_in == CH_MINUS) begin
            skip = 1'b1;
         end else begin
            eff_ph = PH_POS_SIGN;
         end
      end
   end

   assign neg      = (eff_ph == PH_NEG_SIGN) || (eff_ph == PH_NEG_INT) ||
                     (eff_ph == PH_NEG_FRAC);
   assign int_mode = (eff_ph == PH_POS_SIGN) || (eff_ph == PH_NEG_SIGN) ||
                     (eff_ph == PH_POS_INT) || (eff_ph == PH_NEG_INT);

   // Accumulator is kept at full scale: an integer digit shifts by ten and adds d*10^F,
   // a fraction digit adds d at its own decimal weight.
   assign frac_idx = (cur.frac_cnt < 4'(FRAC_DIGITS)) ?
                     (4'(FRAC_DIGITS - 1) - cur.frac_cnt) : 4'd0;
   assign add_amt  = ADD_W'(digit) *
                     ADD_W'(pow10(int_mode ? 4'(FRAC_DIGITS) : frac_idx));
   assign acc_ext  = ACC_EXT_W'(cur.acc);
   assign base     = int_mode ? ((acc_ext <<< 3) + (acc_ext <<< 1)) : acc_ext;
   assign add_ext  = signed'({{(ACC_EXT_W-ADD_W){1'b0}}, add_amt});
   assign sum      = neg ? (base - add_ext) : (base + add_ext);

   always_comb begin
      if (sum > WIDE_MAX) begin
         clamped = VALUE_MAX;
      end else if (sum < WIDE_MIN) begin
         clamped = VALUE_MIN;
      end else begin
         clamped = sum[VALUE_W-1:0];
      end
   end

   always_comb begin
      nxt = cur;
      if (skip) begin
         if (char_in == CH_PLUS) begin
            nxt.phase = PH_POS_SIGN;
         end else if (char_in == CH_MINUS) begin
            nxt.phase = PH_NEG_SIGN;
         end
      end else begin
         unique case (eff_ph)
            PH_POS_SIGN, PH_NEG_SIGN, PH_POS_INT, PH_NEG_INT: begin
               if (is_digit) begin
                  nxt.acc   = clamped;
                  nxt.phase = neg ? PH_NEG_INT : PH_POS_INT;
               end else if (char_in == CH_POINT) begin
                  nxt.phase = neg ? PH_NEG_FRAC : PH_POS_FRAC;
               end else begin
                  nxt.phase = PH_STOP;
               end
            end
            PH_POS_FRAC, PH_NEG_FRAC: begin
               if (is_digit) begin
                  // drop decimals beyond the kept precision
                  if (cur.frac_cnt < 4'(FRAC_DIGITS)) begin
                     nxt.acc      = clamped;
                     nxt.frac_cnt = cur.frac_cnt + 4'd1;
                  end
               end else begin
                  nxt.phase = PH_STOP;
               end
            end
            PH_AWAIT, PH_STOP: begin
               nxt = cur;
            end
            default: begin
               nxt = cur;
            end
         endcase
      end
   end

endmodule

/* rtl/nafe_parser.sv */
// Bracket, field and string tracking with the result register.
`timescale 1ns / 1ps

module nafe_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   input  logic [7:0]            text_byte,
   input  logic                  first_byte,
   input  logic                  last_byte,
   input  logic [6:0]            max_values,
   input  logic                  out_ready,
   output logic                  item_take,
   output logic                  rsp_valid,
   output nafe_pkg::result_type  rsp
);
   import nafe_pkg::*;

   logic [7:0]     depth_ff, depth_in;
   logic [2:0]     field_ff, field_in;
   logic           done_ff, done_in;
   logic           in_str_ff, in_str_in;
   logic [6:0]     count_ff, count_in;
   conv_state_type conv_ff, conv_in;
   logic           rsp_valid_ff, rsp_valid_in;
   result_type     rsp_ff, rsp_in;

   logic [7:0]     depth_b;
   logic [2:0]     field_b;
   logic           done_b;
   logic           in_str_b;
   logic [6:0]     count_b;
   conv_state_type conv_b;
   conv_state_type conv_step;
   logic [6:0]     limit;
   logic           emit;

   // a new text starts from a cleared parser
   always_comb begin
      if (first_byte) begin
         depth_b  = '0;
         field_b  = '0;
         done_b   = 1'b0;
         in_str_b = 1'b0;
         count_b  = '0;
         conv_b   = '{phase: PH_AWAIT, frac_cnt: '0, acc: '0};
      end else begin
         depth_b  = depth_ff;
         field_b  = field_ff;
         done_b   = done_ff;
         in_str_b = in_str_ff;
         count_b  = count_ff;
         conv_b   = conv_ff;
      end
   end

   nafe_conv u_conv (
      .char_in (text_byte),
      .cur     (conv_b),
      .nxt     (conv_step)
   );

   assign limit     = (max_values < COUNT_LIMIT) ? max_values : COUNT_LIMIT;
   assign item_take = item_valid && (!rsp_valid_ff || out_ready);

   always_comb begin
      depth_in  = depth_b;
      field_in  = field_b;
      done_in   = done_b;
      in_str_in = in_str_b;
      count_in  = count_b;
      conv_in   = conv_b;
      emit      = 1'b0;
      if (count_b < limit) begin
         if (in_str_b) begin
            if (text_byte == CH_QUOTE) begin
               in_str_in = 1'b0;
               if (depth_b == TARGET_DEPTH && field_b == TARGET_FIELD && !done_b) begin
                  emit     = 1'b1;
                  count_in = count_b + 7'd1;
                  done_in  = 1'b1;
               end
            end else begin
               conv_in = conv_step;
            end
         end else begin
            case (text_byte)
               CH_LBRACK: begin
                  depth_in = depth_b + 8'd1;
                  if (depth_b + 8'd1 == TARGET_DEPTH) begin
                     field_in = '0;
                     done_in  = 1'b0;
                  end
               end
               CH_RBRACK: begin
                  if (depth_b == TARGET_DEPTH) begin
                     field_in = '0;
                     done_in  = 1'b0;
                  end
                  depth_in = depth_b - 8'd1;
               end
               CH_COMMA: begin
                  if (depth_b == TARGET_DEPTH && !done_b && field_b < FIELD_MAX) begin
                     field_in = field_b + 3'd1;
                  end
               end
               CH_QUOTE: begin
                  if (depth_b == TARGET_DEPTH) begin
                     in_str_in = 1'b1;
                     conv_in   = '{phase: PH_AWAIT, frac_cnt: '0, acc: '0};
                  end
               end
               default: begin
                  depth_in = depth_b;
               end
            endcase
         end
      end
   end

   always_comb begin
      rsp_in.has_value   = emit;
      rsp_in.value       = emit ? conv_b.acc : '0;
      rsp_in.value_index = emit ? count_b[5:0] : 6'd0;
      rsp_in.text_done   = last_byte;
      rsp_in.value_count = count_in;
      if (item_take) begin
         rsp_valid_in = emit || last_byte;
      end else if (out_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff     <= '0;
         field_ff     <= '0;
         done_ff      <= 1'b0;
         in_str_ff    <= 1'b0;
         count_ff     <= '0;
         conv_ff      <= '{phase: PH_AWAIT, frac_cnt: '0, acc: '0};
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (item_take) begin
            depth_ff  <= depth_in;
            field_ff  <= field_in;
            done_ff   <= done_in;
            in_str_ff <= in_str_in;
            count_ff  <= count_in;
            conv_ff   <= conv_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_LIMIT)
      else $error("value count beyond limit");

   a_string_at_depth: assert property (@(posedge clock) disable iff (reset)
      in_str_ff |-> depth_ff == TARGET_DEPTH)
      else $error("string open off the inner array depth");

   a_finished_on_target: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> field_ff == TARGET_FIELD)
      else $error("record finished outside the target field");

   a_index_matches_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.has_value) |->
         rsp_ff.value_count == {1'b0, rsp_ff.value_index} + 7'd1)
      else $error("value index does not match count");

endmodule
